// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define PHC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Overlapping implication built on the plain form.
`define PHC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `PHC_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// ===== rtl/phc_pkg.sv =====
// Shared constants, types and the checksum helper of the header parser.
`default_nettype none

package phc_pkg;

  // Frame layout
  localparam int unsigned MaxFrameBytesDef = 16384;
  localparam int unsigned EthHdrLen        = 14;
  localparam int unsigned EtypeHiPos       = 12;
  localparam int unsigned EtypeLoPos       = 13;
  localparam int unsigned TotW             = 16;

  // IPv4 header byte offsets
  localparam int unsigned IpIhlPos    = 0;
  localparam int unsigned IpTotHiPos  = 2;
  localparam int unsigned IpTotLoPos  = 3;
  localparam int unsigned IpTtlPos    = 8;
  localparam int unsigned IpProtoPos  = 9;
  localparam int unsigned IpAddrFirst = 12;
  localparam int unsigned IpAddrEnd   = 20;
  localparam int unsigned MinIpHdr    = 20;

  // Layer 4 byte offsets, relative to the end of the IP header
  localparam int unsigned L4SrcEnd   = 2;
  localparam int unsigned L4DstEnd   = 4;
  localparam int unsigned L4SeqEnd   = 8;
  localparam int unsigned L4AckEnd   = 12;
  localparam int unsigned L4FlagsPos = 13;

  localparam logic [15:0] EtypeIpv4  = 16'h0800;
  localparam logic [15:0] EtypeArp   = 16'h0806;
  localparam logic [7:0]  ProtoIcmp  = 8'd1;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [15:0] SumAllOnes = 16'hFFFF;

  typedef enum logic [1:0] {
    L3_UNKNOWN = 2'd0,
    L3_IPV4    = 2'd1,
    L3_ARP     = 2'd2
  } l3_kind_e;

  typedef enum logic [1:0] {
    L4_OTHER = 2'd0,
    L4_ICMP  = 2'd1,
    L4_TCP   = 2'd2,
    L4_UDP   = 2'd3
  } l4_kind_e;

  // Frame state captured on the last byte
  typedef struct packed {
    logic [15:0] ethertype;
    logic [5:0]  ihl;
    logic [15:0] total_len;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] ip_sum;
    logic [15:0] tcp_sum;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [3:0]  flags;
    logic        hdr_arrived;
    logic        seg_arrived;
  } frame_sum_t;

  // Ones'-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/phc_parse.sv =====
// Per-byte parser: frame state, running checksums and the last-byte snapshot.
`default_nettype none

module phc_parse #(
  parameter int unsigned MAX_FRAME_BYTES = phc_pkg::MaxFrameBytesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  input  wire logic [7:0]        item_byte_i,
  input  wire logic              item_last_i,
  output logic                   item_ready_o,
  output logic                   snap_valid_o,
  output phc_pkg::frame_sum_t    snap_o,
  input  wire logic              snap_ready_i
);
  import phc_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CmpW = (IdxW > TotW + 1) ? IdxW : TotW + 1;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     etype_q, etype_d;
  logic [5:0]      ihl_q, ihl_d;
  logic [15:0]     tot_q, tot_d;
  logic [7:0]      ttl_q, ttl_d;
  logic [7:0]      proto_q, proto_d;
  logic [15:0]     ip_sum_q, ip_sum_d;
  logic [15:0]     tcp_sum_q, tcp_sum_d;
  logic [15:0]     src_q, src_d;
  logic [15:0]     dst_q, dst_d;
  logic [31:0]     seq_q, seq_d;
  logic [31:0]     ack_q, ack_d;
  logic [3:0]      flags_q, flags_d;

  logic            snap_valid_q, snap_valid_d;
  frame_sum_t      snap_q, snap_d;

  logic            take;
  logic            ip_active;
  logic            adv;
  logic [IdxW-1:0] k;
  logic [IdxW-1:0] j;
  logic [15:0]     w;
  logic            in_hdr;
  logic            in_seg;
  logic            in_addr;
  logic [15:0]     tcp_mid;
  logic [7:0]      b;

  assign b = item_byte_i;

  // Last bytes wait for the snapshot register; other bytes always pass
  assign item_ready_o = !item_last_i || !snap_valid_q || snap_ready_i;
  assign adv          = item_valid_i && item_ready_o;

  // Decode the byte position and build the next frame state
  always_comb begin
    take      = idx_q < IdxW'(MAX_FRAME_BYTES);
    k         = idx_q - IdxW'(EthHdrLen);
    ip_active = take && (idx_q >= IdxW'(EthHdrLen)) && (etype_q == EtypeIpv4);
    w         = k[0] ? {8'd0, b} : {b, 8'd0};

    idx_d     = take ? idx_q + IdxW'(1) : idx_q;
    etype_d   = etype_q;
    ihl_d     = ihl_q;
    tot_d     = tot_q;
    ttl_d     = ttl_q;
    proto_d   = proto_q;
    ip_sum_d  = ip_sum_q;
    tcp_sum_d = tcp_sum_q;
    src_d     = src_q;
    dst_d     = dst_q;
    seq_d     = seq_q;
    ack_d     = ack_q;
    flags_d   = flags_q;

    if (take && idx_q == IdxW'(EtypeHiPos)) begin
      etype_d[15:8] = b;
    end
    if (take && idx_q == IdxW'(EtypeLoPos)) begin
      etype_d[7:0] = b;
    end

    // Header fields land before the sums look at them
    if (ip_active) begin
      if (k == IdxW'(IpIhlPos))   ihl_d      = {b[3:0], 2'b00};
      if (k == IdxW'(IpTotHiPos)) tot_d[15:8] = b;
      if (k == IdxW'(IpTotLoPos)) tot_d[7:0]  = b;
      if (k == IdxW'(IpTtlPos))   ttl_d      = b;
      if (k == IdxW'(IpProtoPos)) proto_d    = b;
    end

    in_hdr  = CmpW'(k) < CmpW'(ihl_d);
    in_seg  = !in_hdr && (CmpW'(k) < CmpW'(tot_d));
    in_addr = (k >= IdxW'(IpAddrFirst)) && (k < IdxW'(IpAddrEnd));
    j       = k - IdxW'(ihl_d);
    tcp_mid = (ip_active && in_addr) ? ones_add(tcp_sum_q, w) : tcp_sum_q;

    if (ip_active) begin
      if (in_hdr) ip_sum_d = ones_add(ip_sum_q, w);
      tcp_sum_d = in_seg ? ones_add(tcp_mid, w) : tcp_mid;
      if (!in_hdr) begin
        if (j < IdxW'(L4SrcEnd))        src_d = {src_q[7:0], b};
        else if (j < IdxW'(L4DstEnd))   dst_d = {dst_q[7:0], b};
        else if (j < IdxW'(L4SeqEnd))   seq_d = {seq_q[23:0], b};
        else if (j < IdxW'(L4AckEnd))   ack_d = {ack_q[23:0], b};
        else if (j == IdxW'(L4FlagsPos)) flags_d = {b[4], b[2], b[1], b[0]};
      end
    end
  end

  // Assemble the snapshot from the state after this byte
  always_comb begin
    snap_d.ethertype   = etype_d;
    snap_d.ihl         = ihl_d;
    snap_d.total_len   = tot_d;
    snap_d.ttl         = ttl_d;
    snap_d.proto       = proto_d;
    snap_d.ip_sum      = ip_sum_d;
    snap_d.tcp_sum     = tcp_sum_d;
    snap_d.src_port    = src_d;
    snap_d.dst_port    = dst_d;
    snap_d.seq         = seq_d;
    snap_d.ack         = ack_d;
    snap_d.flags       = flags_d;
    snap_d.hdr_arrived = CmpW'(idx_d) >= CmpW'(EthHdrLen) + CmpW'(ihl_d);
    snap_d.seg_arrived = CmpW'(idx_d) >= CmpW'(EthHdrLen) + CmpW'(tot_d);

    snap_valid_d = snap_valid_q;
    if (snap_ready_i) snap_valid_d = 1'b0;
    if (adv && item_last_i) snap_valid_d = 1'b1;
  end

  // Advance the frame state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      etype_q   <= '0;
      ihl_q     <= '0;
      tot_q     <= '0;
      ttl_q     <= '0;
      proto_q   <= '0;
      ip_sum_q  <= '0;
      tcp_sum_q <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      seq_q     <= '0;
      ack_q     <= '0;
      flags_q   <= '0;
    end else if (adv) begin
      if (item_last_i) begin
        idx_q     <= '0;
        etype_q   <= '0;
        ihl_q     <= '0;
        tot_q     <= '0;
        ttl_q     <= '0;
        proto_q   <= '0;
        ip_sum_q  <= '0;
        tcp_sum_q <= '0;
        src_q     <= '0;
        dst_q     <= '0;
        seq_q     <= '0;
        ack_q     <= '0;
        flags_q   <= '0;
      end else begin
        idx_q     <= idx_d;
        etype_q   <= etype_d;
        ihl_q     <= ihl_d;
        tot_q     <= tot_d;
        ttl_q     <= ttl_d;
        proto_q   <= proto_d;
        ip_sum_q  <= ip_sum_d;
        tcp_sum_q <= tcp_sum_d;
        src_q     <= src_d;
        dst_q     <= dst_d;
        seq_q     <= seq_d;
        ack_q     <= ack_d;
        flags_q   <= flags_d;
      end
    end
  end

  // Hold the snapshot until the summary stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && item_last_i) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

`default_nettype wire

// ===== rtl/phc_summary.sv =====
// Summary stage: classification, final checksum checks and the result register.
`default_nettype none

module phc_summary (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           snap_valid_i,
  input  phc_pkg::frame_sum_t snap_i,
  output logic                snap_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          l3_kind_o,
  output logic [1:0]          l4_kind_o,
  output logic [5:0]          ip_header_bytes_o,
  output logic [15:0]         ip_total_length_o,
  output logic [7:0]          time_to_live_o,
  output logic                ip_checksum_ok_o,
  output logic [15:0]         source_port_o,
  output logic [15:0]         dest_port_o,
  output logic [31:0]         tcp_sequence_o,
  output logic [31:0]         tcp_ack_number_o,
  output logic [3:0]          ctrl_flags_o,
  output logic                tcp_checksum_ok_o
);
  import phc_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        load;
  l3_kind_e    l3_d;
  l4_kind_e    l4_d;
  logic        ipv4, tcp, ports;
  logic [15:0] seg_len;
  logic [15:0] sum_proto;
  logic [15:0] sum_full;
  logic        tcp_ok_d, ip_ok_d;

  logic [1:0]  l3_q;
  logic [1:0]  l4_q;
  logic [5:0]  ihl_q;
  logic [15:0] tot_q;
  logic [7:0]  ttl_q;
  logic        ip_ok_q;
  logic [15:0] src_q, dst_q;
  logic [31:0] seq_q, ack_q;
  logic [3:0]  flags_q;
  logic        tcp_ok_q;

  assign snap_ready_o = !out_valid_q || out_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  // Classify the frame and finish both checksums
  always_comb begin
    ipv4 = snap_i.ethertype == EtypeIpv4;
    if (ipv4) l3_d = L3_IPV4;
    else if (snap_i.ethertype == EtypeArp) l3_d = L3_ARP;
    else l3_d = L3_UNKNOWN;

    l4_d = L4_OTHER;
    if (ipv4) begin
      case (snap_i.proto)
        ProtoIcmp: l4_d = L4_ICMP;
        ProtoTcp:  l4_d = L4_TCP;
        ProtoUdp:  l4_d = L4_UDP;
        default:   l4_d = L4_OTHER;
      endcase
    end
    tcp   = l4_d == L4_TCP;
    ports = tcp || (l4_d == L4_UDP);

    ip_ok_d   = ipv4 && snap_i.hdr_arrived && (snap_i.ip_sum == SumAllOnes);
    seg_len   = snap_i.total_len - {10'd0, snap_i.ihl};
    sum_proto = ones_add(snap_i.tcp_sum, {8'd0, snap_i.proto});
    sum_full  = ones_add(sum_proto, seg_len);
    tcp_ok_d  = tcp && (snap_i.ihl >= 6'(MinIpHdr)) &&
                (snap_i.total_len >= {10'd0, snap_i.ihl}) &&
                snap_i.seg_arrived && (sum_full == SumAllOnes);

    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register; drop fields that do not apply
  always_ff @(posedge clk_i) begin
    if (load) begin
      l3_q     <= l3_d;
      l4_q     <= l4_d;
      ihl_q    <= ipv4 ? snap_i.ihl : 6'd0;
      tot_q    <= ipv4 ? snap_i.total_len : 16'd0;
      ttl_q    <= ipv4 ? snap_i.ttl : 8'd0;
      ip_ok_q  <= ip_ok_d;
      src_q    <= ports ? snap_i.src_port : 16'd0;
      dst_q    <= ports ? snap_i.dst_port : 16'd0;
      seq_q    <= tcp ? snap_i.seq : 32'd0;
      ack_q    <= tcp ? snap_i.ack : 32'd0;
      flags_q  <= tcp ? snap_i.flags : 4'd0;
      tcp_ok_q <= tcp_ok_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign l3_kind_o         = l3_q;
  assign l4_kind_o         = l4_q;
  assign ip_header_bytes_o = ihl_q;
  assign ip_total_length_o = tot_q;
  assign time_to_live_o    = ttl_q;
  assign ip_checksum_ok_o  = ip_ok_q;
  assign source_port_o     = src_q;
  assign dest_port_o       = dst_q;
  assign tcp_sequence_o    = seq_q;
  assign tcp_ack_number_o  = ack_q;
  assign ctrl_flags_o      = flags_q;
  assign tcp_checksum_ok_o = tcp_ok_q;

endmodule

`default_nettype wire

// ===== rtl/packet_header_parser_checksum_top.sv =====
// Top level of the Ethernet/IPv4 header parser with Internet checksum checks.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//   out     | out_valid_o/out_ready_i | l3_kind_o .. tcp_checksum_ok_o (12 fields)
//
// One byte a cycle unless stalled: the input register feeds the parser, which
// updates the frame state and both ones'-complement sums as it takes each byte.
// A last byte passes input and snapshot registers before the result register.
// Only last bytes can stall: snapshot and result registers full, out_ready_i low.
// Reset clears all frame state; no clearing pass is needed.
`default_nettype none

module packet_header_parser_checksum_top #(
  parameter int unsigned MAX_FRAME_BYTES = phc_pkg::MaxFrameBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       l3_kind_o,
  output logic [1:0]       l4_kind_o,
  output logic [5:0]       ip_header_bytes_o,
  output logic [15:0]      ip_total_length_o,
  output logic [7:0]       time_to_live_o,
  output logic             ip_checksum_ok_o,
  output logic [15:0]      source_port_o,
  output logic [15:0]      dest_port_o,
  output logic [31:0]      tcp_sequence_o,
  output logic [31:0]      tcp_ack_number_o,
  output logic [3:0]       ctrl_flags_o,
  output logic             tcp_checksum_ok_o
);
  import phc_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       item_ready;
  logic       snap_valid;
  logic       snap_ready;
  frame_sum_t snap;

  // Input register: refill when empty or when the parser takes the held byte
  assign in_ready_o = !in_valid_q || item_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (item_ready) in_valid_d = 1'b0;
    if (in_valid_i && in_ready_o) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  phc_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_byte_i  (in_byte_q),
    .item_last_i  (in_last_q),
    .item_ready_o (item_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  phc_summary u_summary (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .snap_valid_i      (snap_valid),
    .snap_i            (snap),
    .snap_ready_o      (snap_ready),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .l3_kind_o         (l3_kind_o),
    .l4_kind_o         (l4_kind_o),
    .ip_header_bytes_o (ip_header_bytes_o),
    .ip_total_length_o (ip_total_length_o),
    .time_to_live_o    (time_to_live_o),
    .ip_checksum_ok_o  (ip_checksum_ok_o),
    .source_port_o     (source_port_o),
    .dest_port_o       (dest_port_o),
    .tcp_sequence_o    (tcp_sequence_o),
    .tcp_ack_number_o  (tcp_ack_number_o),
    .ctrl_flags_o      (ctrl_flags_o),
    .tcp_checksum_ok_o (tcp_checksum_ok_o)
  );

endmodule

`default_nettype wire

// ===== rtl/phc_checker.sv =====
// Port-level assertions for the header parser, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module phc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  data_byte_i,
  input wire logic        last_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  l3_kind_o,
  input wire logic [1:0]  l4_kind_o,
  input wire logic [5:0]  ip_header_bytes_o,
  input wire logic [15:0] ip_total_length_o,
  input wire logic [7:0]  time_to_live_o,
  input wire logic        ip_checksum_ok_o,
  input wire logic [15:0] source_port_o,
  input wire logic [15:0] dest_port_o,
  input wire logic [31:0] tcp_sequence_o,
  input wire logic [31:0] tcp_ack_number_o,
  input wire logic [3:0]  ctrl_flags_o,
  input wire logic        tcp_checksum_ok_o
);
  import phc_pkg::*;

  logic [2:0] pending_q;
  logic       last_in;
  logic       res_out;
  logic [7:0] byte_seen;

  assign last_in   = in_valid_i && in_ready_o && last_byte_i;
  assign res_out   = out_valid_o && out_ready_i;
  assign byte_seen = data_byte_i;

  // Track frames ended at the input whose results have not yet left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (last_in && !res_out) begin
      pending_q <= pending_q + 3'd1;
    end else if (res_out && !last_in) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  `PHC_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    ##1 (out_valid_o && $stable(tcp_sequence_o) && $stable(l3_kind_o)),
    "result dropped while stalled")
  `PHC_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, out_valid_o, pending_q != 3'd0,
    "result without a last byte")
  `PHC_ASSERT(a_capacity, clk_i, rst_ni, pending_q <= 3'd3, "more frames in flight than stages")
  `PHC_ASSERT_IMP(a_tcp_fields, clk_i, rst_ni, out_valid_o && l4_kind_o != L4_TCP,
    (tcp_checksum_ok_o == 1'b0) && (ctrl_flags_o == 4'd0) && (tcp_ack_number_o == 32'd0) &&
    (byte_seen == byte_seen),
    "TCP fields set on a non-TCP result")
  `PHC_ASSERT_IMP(a_ipv4_fields, clk_i, rst_ni, out_valid_o && l3_kind_o != L3_IPV4,
    (l4_kind_o == L4_OTHER) && (ip_header_bytes_o == 6'd0) && (ip_total_length_o == 16'd0) &&
    (time_to_live_o == 8'd0) && !ip_checksum_ok_o && (source_port_o == 16'd0) &&
    (dest_port_o == 16'd0),
    "IPv4 fields set on a non-IPv4 result")

endmodule

bind packet_header_parser_checksum_top phc_checker u_phc_checker (.*);

`default_nettype wire
